// ===== hw/rtl/two_point_secret_recovery_top_macros.svh =====
// assertion macros for the two-point secret recovery block
`ifndef TWO_POINT_SECRET_RECOVERY_TOP_MACROS_SVH
`define TWO_POINT_SECRET_RECOVERY_TOP_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define TPSR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication checked outside reset
`define TPSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/tpsr_pkg.sv =====
// shared types and constants of the two-point secret recovery block
package tpsr_pkg;
	localparam int unsigned Width = 32;
	localparam int unsigned CntW = 7;
	localparam logic [Width-1:0] ModulusReset = 32'hFFFF_FFFB;

	typedef struct packed {
		logic [Width-1:0] first_x;
		logic [Width-1:0] first_y;
		logic [Width-1:0] second_x;
		logic [Width-1:0] second_y;
	} in_item_t;

	typedef struct packed {
		logic [Width-1:0] secret;
		logic [Width-1:0] slope;
		logic             bad_points;
	} out_item_t;

	// operation codes of the shared bit-serial unit
	typedef enum logic [1:0] {
		OP_MOD = 2'd0,
		OP_MUL = 2'd1,
		OP_DIV = 2'd2
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} unit_ctl_t;

	typedef struct packed {
		logic done;
		logic busy;
	} unit_sts_t;
endpackage

// ===== hw/rtl/two_point_secret_recovery_top.sv =====
// top level of the two-point secret recovery block
// Recovers f(0) and the slope of a line through two share points over the
// integers modulo the modulus register. A transaction is taken when start is
// high and busy is low; the result appears for exactly one cycle with done
// high and cannot be held off, so capture it then. Every bit-serial operation
// runs on the single shared unit: four reductions, then per extended Euclidean
// round one division, one modular multiply and an update step (at most 45
// rounds for 32-bit values), then two multiplies; the run time is set by that
// shared shift-and-subtract unit. A modulus below two skips the unit entirely.
// The modulus is written through cfg_valid/cfg_ready while the block is idle.
module two_point_secret_recovery_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  tpsr_pkg::in_item_t            in_item,
	output logic                          done,
	output tpsr_pkg::out_item_t           out_item,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tpsr_pkg::Width-1:0]    cfg_data
);
	`include "two_point_secret_recovery_top_macros.svh"
	localparam int unsigned W = tpsr_pkg::Width;

	typedef enum logic [3:0] {
		S_IDLE, S_RED, S_DIFF, S_DIV, S_MUL, S_UPD, S_SLOPE, S_SEC, S_FIN, S_OUT
	} state_t;

	state_t state_q;
	logic [W-1:0] mod_q;
	logic [W-1:0] x1_q, y1_q, x2_q, y2_q;
	logic [W-1:0] r0_q, r1_q, t0_q, t1_q, dy_q, slope_q;
	logic [1:0] idx_q;
	logic bad_q;
	tpsr_pkg::unit_ctl_t ctl_q;
	tpsr_pkg::unit_sts_t sts;
	logic [W-1:0] opa_q, opb_q, quot, rem;
	tpsr_pkg::out_item_t res_q;
	logic done_q;

	tpsr_serial_unit u_unit (
		.clk(clk), .arst_n(arst_n), .ctl(ctl_q), .opa(opa_q), .opb(opb_q),
		.modulus(mod_q), .sts(sts), .quot(quot), .rem(rem)
	);

	// modular subtract of already reduced values
	function automatic logic [W-1:0] sub_mod(input logic [W-1:0] a, input logic [W-1:0] b,
			input logic [W-1:0] p);
		return (a >= b) ? a - b : a + (p - b);
	endfunction

	assign cfg_ready = (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign out_item = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mod_q <= tpsr_pkg::ModulusReset;
			ctl_q <= '{start: 1'b0, op: tpsr_pkg::OP_MOD};
			done_q <= 1'b0;
			idx_q <= '0;
			bad_q <= 1'b0;
		end else begin
			ctl_q.start <= 1'b0;
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						mod_q <= cfg_data;
					end
					if (start) begin
						x1_q <= in_item.first_x;
						y1_q <= in_item.first_y;
						x2_q <= in_item.second_x;
						y2_q <= in_item.second_y;
						bad_q <= 1'b1;
						idx_q <= '0;
						if (mod_q < W'(2)) begin
							state_q <= S_FIN;
						end else begin
							opa_q <= in_item.first_x;
							ctl_q <= '{start: 1'b1, op: tpsr_pkg::OP_MOD};
							state_q <= S_RED;
						end
					end
				end
				S_RED: begin
					if (sts.done) begin
						// reduced coordinates land back in place
						case (idx_q)
							2'd0: begin x1_q <= rem; opa_q <= y1_q; end
							2'd1: begin y1_q <= rem; opa_q <= x2_q; end
							2'd2: begin x2_q <= rem; opa_q <= y2_q; end
							default: y2_q <= rem;
						endcase
						idx_q <= idx_q + 1'b1;
						if (idx_q == 2'd3) begin
							state_q <= S_DIFF;
						end else begin
							ctl_q <= '{start: 1'b1, op: tpsr_pkg::OP_MOD};
						end
					end
				end
				S_DIFF: begin
					dy_q <= sub_mod(y2_q, y1_q, mod_q);
					r0_q <= mod_q;
					r1_q <= sub_mod(x2_q, x1_q, mod_q);
					t0_q <= '0;
					t1_q <= W'(1);
					if (sub_mod(x2_q, x1_q, mod_q) == '0) begin
						state_q <= S_FIN;
					end else begin
						opa_q <= mod_q;
						opb_q <= sub_mod(x2_q, x1_q, mod_q);
						ctl_q <= '{start: 1'b1, op: tpsr_pkg::OP_DIV};
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (sts.done) begin
						r0_q <= r1_q;
						r1_q <= rem;
						// quotient at most p, which the multiply treats as zero
						opa_q <= quot;
						opb_q <= t1_q;
						ctl_q <= '{start: 1'b1, op: tpsr_pkg::OP_MUL};
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (sts.done) begin
						t0_q <= t1_q;
						t1_q <= sub_mod(t0_q, rem, mod_q);
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (r1_q == '0) begin
						if (r0_q != W'(1)) begin
							state_q <= S_FIN;
						end else begin
							opa_q <= dy_q;
							opb_q <= t0_q;
							ctl_q <= '{start: 1'b1, op: tpsr_pkg::OP_MUL};
							state_q <= S_SLOPE;
						end
					end else begin
						opa_q <= r0_q;
						opb_q <= r1_q;
						ctl_q <= '{start: 1'b1, op: tpsr_pkg::OP_DIV};
						state_q <= S_DIV;
					end
				end
				S_SLOPE: begin
					if (sts.done) begin
						slope_q <= rem;
						opa_q <= x1_q;
						opb_q <= rem;
						ctl_q <= '{start: 1'b1, op: tpsr_pkg::OP_MUL};
						state_q <= S_SEC;
					end
				end
				S_SEC: begin
					if (sts.done) begin
						y2_q <= sub_mod(y1_q, rem, mod_q);
						bad_q <= 1'b0;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					res_q.bad_points <= bad_q;
					res_q.secret <= bad_q ? '0 : y2_q;
					res_q.slope <= bad_q ? '0 : slope_q;
					done_q <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result strobe lasts a single cycle
	`TPSR_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)
	// an error result carries zero values
	`TPSR_ASSERT_IMP(a_bad_zero, clk, arst_n, done && out_item.bad_points,
		out_item.secret == '0 && out_item.slope == '0)
	// the unit never runs while the block is idle
	`TPSR_ASSERT_IMP(a_unit_idle, clk, arst_n, !busy, !sts.busy)
endmodule

// ===== hw/rtl/tpsr_serial_unit.sv =====
// bit-serial unit: reduction, modular multiply and long division, one bit a cycle
module tpsr_serial_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tpsr_pkg::unit_ctl_t           ctl,
	input  logic [tpsr_pkg::Width-1:0]    opa,
	input  logic [tpsr_pkg::Width-1:0]    opb,
	input  logic [tpsr_pkg::Width-1:0]    modulus,
	output tpsr_pkg::unit_sts_t           sts,
	output logic [tpsr_pkg::Width-1:0]    quot,
	output logic [tpsr_pkg::Width-1:0]    rem
);
	localparam int unsigned W = tpsr_pkg::Width;

	logic [W-1:0] acc_q, sh_q, a_q, d_q;
	logic [tpsr_pkg::CntW-1:0] cnt_q;
	logic busy_q, done_q;
	tpsr_pkg::op_t op_q;
	logic [W:0] dbl, sum, trial;
	logic [W-1:0] dred, sred;

	function automatic logic trial_bit(input logic [W:0] v, input logic [W-1:0] d);
		logic [W:0] t;
		t = v - {1'b0, d};
		return t[W];
	endfunction

	// one step: acc = 2*acc + bit (mod/div) or 2*acc + bit*a (mul), reduced mod d
	always_comb begin
		dbl = {acc_q, sh_q[W-1]};
		if (op_q == tpsr_pkg::OP_MUL) begin
			dbl = {acc_q, 1'b0};
		end
		trial = dbl - {1'b0, d_q};
		dred = trial[W] ? dbl[W-1:0] : trial[W-1:0];
		sum = {1'b0, dred} + {1'b0, a_q};
		trial = sum - {1'b0, d_q};
		sred = trial[W] ? sum[W-1:0] : trial[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			op_q <= tpsr_pkg::OP_MOD;
		end else begin
			done_q <= 1'b0;
			if (ctl.start && !busy_q) begin
				busy_q <= 1'b1;
				op_q <= ctl.op;
				cnt_q <= tpsr_pkg::CntW'(W);
				acc_q <= '0;
				sh_q <= (ctl.op == tpsr_pkg::OP_MUL) ? opb : opa;
				a_q <= opa;
				d_q <= (ctl.op == tpsr_pkg::OP_DIV) ? opb : modulus;
			end else if (busy_q) begin
				if (op_q == tpsr_pkg::OP_MUL) begin
					acc_q <= sh_q[W-1] ? sred : dred;
				end else begin
					acc_q <= dred;
				end
				sh_q <= {sh_q[W-2:0], ~trial_bit(dbl, d_q)};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == tpsr_pkg::CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign sts.done = done_q;
	assign sts.busy = busy_q;
	assign quot = sh_q;
	assign rem = acc_q;
endmodule
